// ----- hdl/vap_pkg.sv -----
// ----------------------------------------------------------------------------
// vap_pkg: shared types and constants for vertical acceleration projection
// Word formats that travel along the square root and divider cell chains.
// ----------------------------------------------------------------------------
package vap_pkg;

    localparam int FRAC_BITS = 8;
    localparam int EXT_BITS  = 8;
    localparam int IN_W      = 16;
    localparam int PROD_W    = 2 * IN_W;

    // gravity magnitude window, squared, 2*FRAC_BITS fraction bits
    localparam longint LOW_SQ  = (longint'(9)  << FRAC_BITS) * (longint'(9)  << FRAC_BITS);
    localparam longint HIGH_SQ = (longint'(11) << FRAC_BITS) * (longint'(11) << FRAC_BITS);

    // sum widths
    localparam int SUM_W = PROD_W + 2;

    // square root of S << 2*EXT_BITS; in range S stays below 2^23
    localparam int SQ_X_W    = 40;
    localparam int SQ_ROOT_W = SQ_X_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int SQ_CELLS  = SQ_ROOT_W;

    // divider: numerator |D| << (EXT_BITS+1) plus m, divisor 2m
    localparam int AD_W     = 32;
    localparam int NUM_W    = AD_W + EXT_BITS + 2;
    localparam int DEN_W    = SQ_ROOT_W + 1;
    localparam int DQ_W     = NUM_W - SQ_ROOT_W;
    localparam int DV_REM_W = DEN_W;
    localparam int DV_CELLS = DQ_W;

    localparam int OUT_W = 16;

    typedef struct packed {
        logic                 valid;
        logic                 err;
        logic                 neg;
        logic [AD_W-1:0]      ad;
        logic [SQ_X_W-1:0]    x;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sq_word;

    typedef struct packed {
        logic                 valid;
        logic                 err;
        logic                 neg;
        logic [NUM_W-1:0]     num;
        logic [DEN_W-1:0]     den;
        logic [DV_REM_W-1:0]  rem;
        logic [DQ_W-1:0]      quo;
    } t_dv_word;

endpackage

// ----- hdl/vertical_accel_projection_top.sv -----
// ----------------------------------------------------------------------------
// vertical_accel_projection_top: gravity-projected vertical acceleration
// Dot product over gravity magnitude, with a 9..11 m/s^2 gravity check.
// ----------------------------------------------------------------------------
// A word is taken every cycle while the output is not stalled, and it passes
// through the product stage, sum stage, 20 square-root cells, hand-over stage,
// 22 divider cells and output register. The depth is set by the two cell
// chains, one root bit and one quotient bit per cell. The whole pipeline
// holds while a finished result waits at the output.
module vertical_accel_projection_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_gravity_x,
    input  logic [15:0] i_gravity_y,
    input  logic [15:0] i_gravity_z,
    input  logic [15:0] i_lin_accel_x,
    input  logic [15:0] i_lin_accel_y,
    input  logic [15:0] i_lin_accel_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_vertical_accel,
    output logic        o_sensor_error
);

    logic w_en;

    // stage 0: products
    logic                             r_p_valid;
    logic signed [vap_pkg::PROD_W-1:0] r_gg [3];
    logic signed [vap_pkg::PROD_W-1:0] r_ga [3];

    // stage 1 and chains
    vap_pkg::t_sq_word r_s1;
    vap_pkg::t_sq_word n_s1;
    vap_pkg::t_sq_word w_sq [vap_pkg::SQ_CELLS+1];
    vap_pkg::t_dv_word r_h;
    vap_pkg::t_dv_word n_h;
    vap_pkg::t_dv_word w_dv [vap_pkg::DV_CELLS+1];

    logic                      r_out_valid;
    logic [vap_pkg::OUT_W-1:0] r_out_acc;
    logic                      r_out_err;
    logic [vap_pkg::OUT_W-1:0] n_out_acc;

    logic [vap_pkg::SUM_W-1:0]        w_s;
    logic signed [vap_pkg::SUM_W-1:0] w_d;
    logic [vap_pkg::SUM_W-1:0]        w_ad;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= i_valid;
        end
        if (w_en) begin
            r_gg[0] <= $signed(i_gravity_x) * $signed(i_gravity_x);
            r_gg[1] <= $signed(i_gravity_y) * $signed(i_gravity_y);
            r_gg[2] <= $signed(i_gravity_z) * $signed(i_gravity_z);
            r_ga[0] <= $signed(i_gravity_x) * $signed(i_lin_accel_x);
            r_ga[1] <= $signed(i_gravity_y) * $signed(i_lin_accel_y);
            r_ga[2] <= $signed(i_gravity_z) * $signed(i_lin_accel_z);
        end
    end

    // sums, range test, radicand
    always_comb begin
        w_s = vap_pkg::SUM_W'($unsigned(r_gg[0])) + vap_pkg::SUM_W'($unsigned(r_gg[1]))
            + vap_pkg::SUM_W'($unsigned(r_gg[2]));
        w_d = vap_pkg::SUM_W'(r_ga[0]) + vap_pkg::SUM_W'(r_ga[1]) + vap_pkg::SUM_W'(r_ga[2]);
        w_ad = w_d[vap_pkg::SUM_W-1] ? vap_pkg::SUM_W'(-w_d) : vap_pkg::SUM_W'(w_d);
        n_s1.valid = r_p_valid;
        n_s1.err   = !((64'(w_s) > 64'(vap_pkg::LOW_SQ)) && (64'(w_s) < 64'(vap_pkg::HIGH_SQ)));
        n_s1.neg   = w_d[vap_pkg::SUM_W-1];
        n_s1.ad    = w_ad[vap_pkg::AD_W-1:0];
        n_s1.x     = {w_s[vap_pkg::SQ_X_W-2*vap_pkg::EXT_BITS-1:0],
                      {(2*vap_pkg::EXT_BITS){1'b0}}};
        n_s1.rem   = '0;
        n_s1.root  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1.valid <= n_s1.valid;
        end
        if (w_en) begin
            r_s1.err  <= n_s1.err;
            r_s1.neg  <= n_s1.neg;
            r_s1.ad   <= n_s1.ad;
            r_s1.x    <= n_s1.x;
            r_s1.rem  <= n_s1.rem;
            r_s1.root <= n_s1.root;
        end
    end

    // square root chain
    assign w_sq[0] = r_s1;
    for (genvar k = 0; k < vap_pkg::SQ_CELLS; k++) begin : g_sq
        vap_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_sq[k]),
            .o_word  (w_sq[k+1])
        );
    end

    // hand-over: build rounded numerator and doubled divisor
    always_comb begin
        n_h.valid = w_sq[vap_pkg::SQ_CELLS].valid;
        n_h.err   = w_sq[vap_pkg::SQ_CELLS].err;
        n_h.neg   = w_sq[vap_pkg::SQ_CELLS].neg;
        n_h.num   = {1'b0, w_sq[vap_pkg::SQ_CELLS].ad, {(vap_pkg::EXT_BITS+1){1'b0}}}
                  + vap_pkg::NUM_W'(w_sq[vap_pkg::SQ_CELLS].root);
        n_h.den   = {w_sq[vap_pkg::SQ_CELLS].root, 1'b0};
        n_h.rem   = '0;
        n_h.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h.valid <= 1'b0;
        end else if (w_en) begin
            r_h.valid <= n_h.valid;
        end
        if (w_en) begin
            r_h.err <= n_h.err;
            r_h.neg <= n_h.neg;
            r_h.den <= n_h.den;
            r_h.quo <= n_h.quo;
            // top numerator bits seed the remainder
            r_h.rem <= {1'b0, n_h.num[vap_pkg::NUM_W-1 -: vap_pkg::SQ_ROOT_W]};
            r_h.num <= {n_h.num[vap_pkg::DQ_W-1:0], {vap_pkg::SQ_ROOT_W{1'b0}}};
        end
    end

    // divider chain, numerator bits taken from num[DQ_W-1] after realignment
    vap_pkg::t_dv_word w_h_al;
    always_comb begin
        w_h_al     = r_h;
        w_h_al.num = {{vap_pkg::SQ_ROOT_W{1'b0}},
                      r_h.num[vap_pkg::NUM_W-1 -: vap_pkg::DQ_W]};
    end
    assign w_dv[0] = w_h_al;
    for (genvar k = 0; k < vap_pkg::DV_CELLS; k++) begin : g_dv
        vap_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_dv[k]),
            .o_word  (w_dv[k+1])
        );
    end

    // error zeroing, sign and saturation
    always_comb begin
        if (w_dv[vap_pkg::DV_CELLS].err) begin
            n_out_acc = '0;
        end else if (w_dv[vap_pkg::DV_CELLS].neg) begin
            if (w_dv[vap_pkg::DV_CELLS].quo > vap_pkg::DQ_W'(32768)) begin
                n_out_acc = 16'h8000;
            end else begin
                n_out_acc = vap_pkg::OUT_W'(-w_dv[vap_pkg::DV_CELLS].quo);
            end
        end else if (w_dv[vap_pkg::DV_CELLS].quo > vap_pkg::DQ_W'(32767)) begin
            n_out_acc = 16'h7FFF;
        end else begin
            n_out_acc = w_dv[vap_pkg::DV_CELLS].quo[vap_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[vap_pkg::DV_CELLS].valid;
        end
        if (w_en) begin
            r_out_acc <= n_out_acc;
            r_out_err <= w_dv[vap_pkg::DV_CELLS].err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_vertical_accel = r_out_acc;
    assign o_sensor_error   = r_out_err;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sensor_error |-> o_vertical_accel == '0)
        else $error("error word with nonzero acceleration");
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_h.valid) && $stable(r_s1.valid))
        else $error("pipeline moved while stalled");

endmodule

// ----- hdl/vap_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// vap_sqrt_cell: one digit of the integer square root chain
// Takes two radicand bits, settles one root bit, hands the word on.
// ----------------------------------------------------------------------------
module vap_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vap_pkg::t_sq_word i_word,
    output vap_pkg::t_sq_word o_word
);

    vap_pkg::t_sq_word r_word;
    vap_pkg::t_sq_word n_word;
    logic [vap_pkg::SQ_REM_W+1:0] w_r2;
    logic [vap_pkg::SQ_REM_W+1:0] w_trial;
    logic [vap_pkg::SQ_REM_W+1:0] w_diff;
    logic                         w_ge;

    // trial subtract of (root<<2)|1
    always_comb begin
        w_r2    = {i_word.rem, i_word.x[vap_pkg::SQ_X_W-1 -: 2]};
        w_trial = {2'b00, i_word.root, 2'b01};
        w_diff  = w_r2 - w_trial;
        w_ge    = (w_r2 >= w_trial);
        n_word      = i_word;
        n_word.x    = {i_word.x[vap_pkg::SQ_X_W-3:0], 2'b00};
        n_word.rem  = w_ge ? w_diff[vap_pkg::SQ_REM_W-1:0] : w_r2[vap_pkg::SQ_REM_W-1:0];
        n_word.root = {i_word.root[vap_pkg::SQ_ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word.valid <= n_word.valid;
        end
        if (i_en) begin
            r_word.err  <= n_word.err;
            r_word.neg  <= n_word.neg;
            r_word.ad   <= n_word.ad;
            r_word.x    <= n_word.x;
            r_word.rem  <= n_word.rem;
            r_word.root <= n_word.root;
        end
    end

    assign o_word = r_word;

endmodule

// ----- hdl/vap_div_cell.sv -----
// ----------------------------------------------------------------------------
// vap_div_cell: one quotient bit of the restoring divider chain
// Shifts in one numerator bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module vap_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vap_pkg::t_dv_word i_word,
    output vap_pkg::t_dv_word o_word
);

    vap_pkg::t_dv_word r_word;
    vap_pkg::t_dv_word n_word;
    logic [vap_pkg::DV_REM_W:0] w_t;
    logic [vap_pkg::DV_REM_W:0] w_d;
    logic [vap_pkg::DV_REM_W:0] w_diff;
    logic                       w_ge;

    // trial subtract of the divisor
    always_comb begin
        w_t    = {i_word.rem, i_word.num[vap_pkg::DQ_W-1]};
        w_d    = {1'b0, i_word.den};
        w_diff = w_t - w_d;
        w_ge   = (w_t >= w_d);
        n_word     = i_word;
        n_word.num = {i_word.num[vap_pkg::NUM_W-2:0], 1'b0};
        n_word.rem = w_ge ? w_diff[vap_pkg::DV_REM_W-1:0] : w_t[vap_pkg::DV_REM_W-1:0];
        n_word.quo = {i_word.quo[vap_pkg::DQ_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word.valid <= n_word.valid;
        end
        if (i_en) begin
            r_word.err <= n_word.err;
            r_word.neg <= n_word.neg;
            r_word.num <= n_word.num;
            r_word.den <= n_word.den;
            r_word.rem <= n_word.rem;
            r_word.quo <= n_word.quo;
        end
    end

    assign o_word = r_word;

endmodule

// ----- tb/sv/vertical_accel_projection_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_accel_projection_checker: result predictor and scoreboard
// Watches both handshakes of the projection block, predicts the vertical
// acceleration and error flag of every accepted word, and compares in order.
// ----------------------------------------------------------------------------
module vertical_accel_projection_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_gravity_x,
    input  logic [15:0] i_gravity_y,
    input  logic [15:0] i_gravity_z,
    input  logic [15:0] i_lin_accel_x,
    input  logic [15:0] i_lin_accel_y,
    input  logic [15:0] i_lin_accel_z,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_vertical_accel,
    input  logic        i_sensor_error,
    output int          o_err_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] vaccel;
        logic        serr;
    } t_projection;

    t_projection projection_q[$];
    int          err_count = 0;

    assign o_err_count = err_count;
    assign o_pending   = projection_q.size();

    // integer square root, truncated, bit-pair method
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned one;
        root = 0;
        one  = 64'd1 << 62;
        while (one > x) one = one >> 2;
        while (one != 0) begin
            if (x >= root + one) begin
                x    = x - (root + one);
                root = (root >> 1) + one;
            end else begin
                root = root >> 1;
            end
            one = one >> 2;
        end
        return root;
    endfunction

    // dot product over gravity magnitude, rounded half away from zero
    function automatic t_projection project_vertical(
        input logic signed [15:0] gx, gy, gz, ax, ay, az);
        t_projection     res;
        longint          gsq;
        longint          dot;
        longint unsigned dot_mag;
        longint unsigned mag;
        longint unsigned quo;
        gsq = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
        if (!(gsq > vap_pkg::LOW_SQ && gsq < vap_pkg::HIGH_SQ)) begin
            res.vaccel = '0;
            res.serr   = 1'b1;
            return res;
        end
        dot     = longint'(gx) * ax + longint'(gy) * ay + longint'(gz) * az;
        dot_mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        mag     = floor_sqrt(longint'(gsq) << (2 * vap_pkg::EXT_BITS));
        quo     = ((dot_mag << (vap_pkg::EXT_BITS + 1)) + mag) / (mag << 1);
        if (dot < 0)
            res.vaccel = (quo > 32768) ? 16'h8000 : 16'(-longint'(quo));
        else
            res.vaccel = (quo > 32767) ? 16'h7fff : 16'(quo);
        res.serr = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // scoreboard: predict on input word, compare on output word
    always @(posedge i_clk) begin
        t_projection want;
        if (i_rst_n && i_in_valid && i_in_ready)
            projection_q.push_back(project_vertical(i_gravity_x, i_gravity_y, i_gravity_z,
                                                    i_lin_accel_x, i_lin_accel_y,
                                                    i_lin_accel_z));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (projection_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = projection_q.pop_front();
                if (i_vertical_accel !== want.vaccel)
                    report_mismatch("vertical_accel", $signed(i_vertical_accel),
                                    $signed(want.vaccel));
                if (i_sensor_error !== want.serr)
                    report_mismatch("sensor_error", i_sensor_error, want.serr);
            end
        end
    end

endmodule

// ----- tb/sv/vertical_accel_projection_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_accel_projection_top_tb: stimulus and verdict
// Directed gravity-window edges and saturation, then mostly in-window
// random reports with random gaps and output stalls, one long hold.
// ----------------------------------------------------------------------------
module vertical_accel_projection_top_tb;

    localparam int RANDOM_WORDS = 730;
    localparam int DRAIN_CYCLES = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_gravity_x = '0;
    logic [15:0] i_gravity_y = '0;
    logic [15:0] i_gravity_z = '0;
    logic [15:0] i_lin_accel_x = '0;
    logic [15:0] i_lin_accel_y = '0;
    logic [15:0] i_lin_accel_z = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_vertical_accel;
    logic        o_sensor_error;
    int          err_count;
    int          pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vertical_accel_projection_top dut (.*);

    vertical_accel_projection_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_gravity_x, .i_gravity_y, .i_gravity_z,
        .i_lin_accel_x, .i_lin_accel_y, .i_lin_accel_z,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_vertical_accel(o_vertical_accel), .i_sensor_error(o_sensor_error),
        .o_err_count(err_count), .o_pending(pending)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_report(input logic [15:0] gx, gy, gz, ax, ay, az, input bit no_gap);
        int gap;
        i_valid       <= 1'b1;
        i_gravity_x   <= gx;
        i_gravity_y   <= gy;
        i_gravity_z   <= gz;
        i_lin_accel_x <= ax;
        i_lin_accel_y <= ay;
        i_lin_accel_z <= az;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        gap = no_gap ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // gravity in the 9..11 window, random direction by rejection
    task automatic pick_gravity(output logic [15:0] gx, gy, gz);
        longint gsq;
        do begin
            gx  = 16'($signed($urandom_range(0, 5632)) - 2816);
            gy  = 16'($signed($urandom_range(0, 5632)) - 2816);
            gz  = 16'($signed($urandom_range(0, 5632)) - 2816);
            gsq = longint'($signed(gx)) * $signed(gx) + longint'($signed(gy)) * $signed(gy)
                + longint'($signed(gz)) * $signed(gz);
        end while (!(gsq > vap_pkg::LOW_SQ && gsq < vap_pkg::HIGH_SQ));
    endtask

    // output side: random stalls, one long hold early in the run
    initial begin
        int gap;
        @(posedge i_rst_n);
        repeat (60) begin
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
        i_ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        logic [15:0] gx, gy, gz, ax, ay, az;
        int          mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // gravity window edges: zero, exactly 9 and 11, just inside, just outside
        send_report(16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256, 1'b1);
        send_report(16'd0, 16'd0, 16'd2304, 16'd512, 16'd0, 16'd0, 1'b1);
        send_report(16'd0, 16'd0, 16'd2816, 16'd0, 16'd0, 16'd512, 1'b1);
        send_report(16'd0, 16'd0, 16'd2305, 16'd0, 16'd0, 16'd1000, 1'b1);
        send_report(16'd0, 16'd2815, 16'd0, 16'd0, 16'hfc00, 16'd0, 1'b0);
        send_report(16'd2303, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 1'b0);
        send_report(16'd0, 16'd0, 16'd2817, 16'd100, 16'd0, 16'd0, 1'b0);
        send_report(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_report(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        // saturation both ways, negative gravity components
        send_report(16'd0, 16'd0, 16'd2560, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_report(16'd0, 16'd0, 16'd2560, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_report(16'd0, 16'd0, 16'hf600, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_report(16'hf980, 16'hf980, 16'hf980, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_report(16'd1478, 16'd1478, 16'd1478, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
        send_report(16'd1478, 16'hfa3a, 16'd1478, 16'd0, 16'd0, 16'd0, 1'b0);
        send_report(16'd2560, 16'd0, 16'd0, 16'hffff, 16'd1, 16'hffff, 1'b0);
        send_report(16'd0, 16'hf600, 16'd0, 16'd3, 16'd1, 16'd0, 1'b0);

        // random reports: mostly in-window gravity, some full-range noise
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 8) begin
                pick_gravity(gx, gy, gz);
            end else begin
                gx = 16'($urandom);
                gy = 16'($urandom);
                gz = 16'($urandom);
            end
            if ($urandom_range(0, 3) == 0) begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
            end else begin
                ax = 16'($signed($urandom_range(0, 8192)) - 4096);
                ay = 16'($signed($urandom_range(0, 8192)) - 4096);
                az = 16'($signed($urandom_range(0, 8192)) - 4096);
            end
            // back-to-back stretch for n from 300 to 399
            send_report(gx, gy, gz, ax, ay, az, n >= 300 && n < 400);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
